// ===== sv/slpm_pkg.sv =====
// Shared types and command codes for the string longest-prefix-match block.
`default_nettype none

package slpm_pkg;

  // Command codes carried in the input tuser field.
  localparam logic [1:0] CMD_PREFIX = 2'd0;
  localparam logic [1:0] CMD_ATTR   = 2'd1;
  localparam logic [1:0] CMD_PATH   = 2'd2;

  // One input beat, unpacked from the stream ports.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  entry_index;
    logic [6:0]  byte_pos;
    logic [7:0]  byte_value;
    logic [6:0]  prefix_len;
    logic [15:0] port;
    logic        up;
    logic        last;
  } item_t;

endpackage

`default_nettype wire

// ===== sv/slpm_store.sv =====
// Route table and path buffer memories with command-driven writes and registered reads.
`default_nettype none

module slpm_store #(
  parameter int MAX_ENTRIES  = 128,
  parameter int PREFIX_BYTES = 128,
  parameter int PATH_BYTES   = 256
) (
  input  wire                                              clk,
  input  wire                                              item_en,
  input  wire slpm_pkg::item_t                             item,
  input  wire                                              path_we,
  input  wire  [$clog2(PATH_BYTES)-1:0]                    path_wa,
  input  wire  [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] attr_ra,
  output logic [$clog2(PREFIX_BYTES+1)-1:0]                attr_len,
  output logic [15:0]                                      attr_port,
  output logic                                             attr_up,
  input  wire  [$clog2(MAX_ENTRIES*PREFIX_BYTES)-1:0]      prefix_ra,
  output logic [7:0]                                       prefix_byte,
  input  wire  [$clog2(PATH_BYTES)-1:0]                    path_ra,
  output logic [7:0]                                       path_byte
);

  localparam int EW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LW    = $clog2(PREFIX_BYTES + 1);
  localparam int PSW   = $clog2(MAX_ENTRIES * PREFIX_BYTES);
  localparam int DEPTH = MAX_ENTRIES * PREFIX_BYTES;

  logic [7:0]    prefix_mem [DEPTH];
  logic [LW-1:0] len_mem    [MAX_ENTRIES];
  logic [15:0]   port_mem   [MAX_ENTRIES];
  logic          up_mem     [MAX_ENTRIES];
  logic [7:0]    path_mem   [PATH_BYTES];

  logic           idx_ok;
  logic           pos_ok;
  logic           prefix_we;
  logic           attr_we;
  logic [EW-1:0]  attr_wa;
  logic [PSW-1:0] prefix_wa;
  logic [LW-1:0]  len_wd;

  // Writes to entries or byte positions beyond the table are dropped.
  assign idx_ok    = 32'(item.entry_index) < MAX_ENTRIES;
  assign pos_ok    = 32'(item.byte_pos) < PREFIX_BYTES;
  assign prefix_we = item_en && (item.cmd == slpm_pkg::CMD_PREFIX) && idx_ok && pos_ok;
  assign attr_we   = item_en && (item.cmd == slpm_pkg::CMD_ATTR) && idx_ok;
  assign attr_wa   = EW'(item.entry_index);
  assign prefix_wa = PSW'(32'(item.entry_index) * PREFIX_BYTES + 32'(item.byte_pos));
  assign len_wd    = (32'(item.prefix_len) > PREFIX_BYTES) ? LW'(PREFIX_BYTES)
                                                           : LW'(item.prefix_len);

  always_ff @(posedge clk) begin
    if (prefix_we) begin
      prefix_mem[prefix_wa] <= item.byte_value;
    end
    prefix_byte <= prefix_mem[prefix_ra];
  end

  always_ff @(posedge clk) begin
    if (attr_we) begin
      len_mem[attr_wa]  <= len_wd;
      port_mem[attr_wa] <= item.port;
      up_mem[attr_wa]   <= item.up;
    end
    attr_len  <= len_mem[attr_ra];
    attr_port <= port_mem[attr_ra];
    attr_up   <= up_mem[attr_ra];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_wa] <= item.byte_value;
    end
    path_byte <= path_mem[path_ra];
  end

endmodule

`default_nettype wire

// ===== sv/string_longest_prefix_match.sv =====
// Top level of the string longest-prefix-match route lookup.
// Usage: routes are loaded over the slave stream (s_tuser selects the command):
// prefix byte writes and attribute writes (length, port, up flag) each take one
// beat. Path bytes take one beat each and are stored until the beat with s_tlast
// high, which starts a lookup over the first route_count entries.
// The lookup walks the table with one shared byte comparator. Each entry passes
// through S_ATTR and S_ACHK for its attribute read; an entry that could beat the
// current best then passes through S_BRD and S_BCMP for each compared prefix byte,
// stopping at the first mismatch. s_tready is low throughout a lookup. One result
// beat then appears on the master stream: found in m_tuser, index, port and matched
// length in m_tdata. The result sits in an output register, so new route writes and
// path bytes are taken while it waits; a second lookup that finishes before the
// first result is taken holds until m_tready frees the register. The route_count
// register is written through cfg_we and cfg_wdata; the user must do so only while
// the block is idle, as the block itself does not enforce this.
// Reset (rst, synchronous) empties the path, clears route_count and drops any
// pending result. Table contents are not cleared and must be loaded before use.
`default_nettype none

module string_longest_prefix_match #(
  parameter int MAX_ENTRIES  = 128,
  parameter int PREFIX_BYTES = 128,
  parameter int PATH_BYTES   = 256
) (
  input  wire         clk,
  input  wire         rst,
  // Slave stream carrying commands and path bytes.
  input  wire         s_tvalid,
  output logic        s_tready,
  // s_tdata from bit 0: entry_index[6:0], byte_pos[13:7], byte_value[21:14],
  // prefix_len[28:22], port[44:29], up[45], zero[47:46].
  input  wire  [47:0] s_tdata,
  // s_tuser: cmd[1:0].
  input  wire  [1:0]  s_tuser,
  input  wire         s_tlast,
  // Master stream carrying lookup results.
  output logic        m_tvalid,
  input  wire         m_tready,
  // m_tdata from bit 0: route_index[6:0], route_port[22:7], match_len[29:23],
  // zero[31:30].
  output logic [31:0] m_tdata,
  // m_tuser: found[0].
  output logic        m_tuser,
  // Configuration: route_count.
  input  wire         cfg_we,
  input  wire  [7:0]  cfg_wdata
);

  localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int LW  = $clog2(PREFIX_BYTES + 1);
  localparam int PBW = $clog2(PREFIX_BYTES);
  localparam int PSW = $clog2(MAX_ENTRIES * PREFIX_BYTES);
  localparam int PAW = $clog2(PATH_BYTES);
  localparam int CW  = (LW > PAW) ? LW : PAW;
  localparam int RCW = (ECW > 8) ? ECW : 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ATTR,
    S_ACHK,
    S_BRD,
    S_BCMP,
    S_FIN
  } state_t;

  state_t          state;
  logic [7:0]      route_count;
  logic [PAW-1:0]  path_length;
  logic [ECW-1:0]  e;
  logic [ECW-1:0]  n_lim;
  logic [PSW-1:0]  base;
  logic [PBW-1:0]  k;
  logic            found;
  logic [LW-1:0]   lead_len;
  logic [EW-1:0]   best_idx;
  logic [15:0]     best_port;
  logic            out_found;
  logic [6:0]      out_index;
  logic [15:0]     out_port;
  logic [6:0]      out_len;

  slpm_pkg::item_t item;
  logic            in_acc;
  logic            path_room;
  logic            path_we;
  logic [LW-1:0]   attr_len;
  logic [15:0]     attr_port;
  logic            attr_up;
  logic [7:0]      prefix_byte;
  logic [7:0]      path_byte;
  logic            elig;
  logic            last_byte;

  // Unpack the input beat into its fields.
  assign item.cmd         = s_tuser;
  assign item.entry_index = s_tdata[6:0];
  assign item.byte_pos    = s_tdata[13:7];
  assign item.byte_value  = s_tdata[21:14];
  assign item.prefix_len  = s_tdata[28:22];
  assign item.port        = s_tdata[44:29];
  assign item.up          = s_tdata[45];
  assign item.last        = s_tlast;

  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  // The buffer keeps at most PATH_BYTES-1 bytes; later ones are dropped.
  assign path_room = 32'(path_length) < (PATH_BYTES - 1);
  assign path_we   = in_acc && (item.cmd == slpm_pkg::CMD_PATH) && path_room;

  slpm_store #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .PREFIX_BYTES (PREFIX_BYTES),
    .PATH_BYTES   (PATH_BYTES)
  ) u_store (
    .clk         (clk),
    .item_en     (in_acc),
    .item        (item),
    .path_we     (path_we),
    .path_wa     (path_length),
    .attr_ra     (e[EW-1:0]),
    .attr_len    (attr_len),
    .attr_port   (attr_port),
    .attr_up     (attr_up),
    .prefix_ra   (base + PSW'(k)),
    .prefix_byte (prefix_byte),
    .path_ra     (PAW'(k)),
    .path_byte   (path_byte)
  );

  // An entry is worth comparing only if it is up, non-empty, longer than the
  // current best (so ties keep the lower index) and no longer than the path.
  assign elig = attr_up && (attr_len != '0) && (attr_len > lead_len) &&
                (CW'(attr_len) <= CW'(path_length));
  assign last_byte = (LW'(k) + LW'(1)) == attr_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      path_length <= '0;
      route_count <= '0;
    end else begin
      if (cfg_we) begin
        route_count <= cfg_wdata;
      end
      // In S_FIN a taken result is replaced by the new one in the same cycle.
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && (item.cmd == slpm_pkg::CMD_PATH)) begin
            if (path_room) begin
              path_length <= path_length + PAW'(1);
            end
            if (item.last) begin
              e         <= '0;
              base      <= '0;
              found     <= 1'b0;
              lead_len  <= '0;
              best_idx  <= '0;
              best_port <= '0;
              n_lim     <= (RCW'(route_count) > RCW'(MAX_ENTRIES)) ? ECW'(MAX_ENTRIES)
                                                                   : ECW'(route_count);
              state     <= S_ATTR;
            end
          end
        end
        S_ATTR: begin
          if (e >= n_lim) begin
            state <= S_FIN;
          end else begin
            state <= S_ACHK;
          end
        end
        S_ACHK: begin
          if (elig) begin
            k     <= '0;
            state <= S_BRD;
          end else begin
            e     <= e + ECW'(1);
            base  <= base + PSW'(PREFIX_BYTES);
            state <= S_ATTR;
          end
        end
        S_BRD: begin
          state <= S_BCMP;
        end
        S_BCMP: begin
          if (prefix_byte != path_byte) begin
            e     <= e + ECW'(1);
            base  <= base + PSW'(PREFIX_BYTES);
            state <= S_ATTR;
          end else if (last_byte) begin
            found     <= 1'b1;
            lead_len  <= attr_len;
            best_idx  <= e[EW-1:0];
            best_port <= attr_port;
            e         <= e + ECW'(1);
            base      <= base + PSW'(PREFIX_BYTES);
            state     <= S_ATTR;
          end else begin
            k     <= k + PBW'(1);
            state <= S_BRD;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            out_found   <= found;
            out_index   <= 7'(best_idx);
            out_port    <= best_port;
            out_len     <= 7'(lead_len);
            path_length <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {2'b00, out_len, out_port, out_index};
  assign m_tuser = out_found;

endmodule

`default_nettype wire
